### src/ssed_pkg.sv
`default_nettype none

package ssed_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int PLANES = 3;
	localparam int LINES = 2;
	localparam int LINE_BITS = LINES * SAMPLE_BITS;
	localparam int ENTRY_BITS = PLANES * LINE_BITS;

	localparam int ROW_BITS = 12;
	localparam int CCOL_BITS = 10;
	localparam int FW_BITS = 11;
	localparam int FH_BITS = 13;
	localparam int SB_BITS = 9;
	localparam int MODE_BITS = 2;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 13;
	localparam int MAX_HEIGHT = 4096;

	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SCAN_BORDER = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_DETECT_MODE = 2'd3;

	localparam logic [MODE_BITS-1:0] MODE_MIN = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_MAX = 2'd1;

	localparam logic [FW_BITS-1:0] FW_RESET = 11'd640;
	localparam logic [FH_BITS-1:0] FH_RESET = 13'd480;
	localparam logic [SB_BITS-1:0] SB_RESET = 9'd1;
	localparam logic [MODE_BITS-1:0] MODE_RESET = 2'd2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic frame_start;
		sample_t sample_below;
		sample_t sample_mid;
		sample_t sample_above;
	} in_t;

	typedef struct packed {
		logic center_valid;
		logic is_minimum;
		logic is_maximum;
		logic detected;
		logic [ROW_BITS-1:0] center_row;
		logic [CCOL_BITS-1:0] center_col;
		sample_t center_value;
	} out_t;

	typedef struct packed {
		logic [FW_BITS-1:0] frame_width;
		logic [FH_BITS-1:0] frame_height;
		logic [SB_BITS-1:0] scan_border;
		logic [MODE_BITS-1:0] detect_mode;
	} cfg_t;

	typedef struct packed {
		logic center_valid;
		logic [ROW_BITS-1:0] center_row;
		logic [CCOL_BITS-1:0] center_col;
	} pos_t;

endpackage

`default_nettype wire

### src/ssed_ram.sv
`default_nettype none

module ssed_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### src/ssed_pos.sv
`default_nettype none

module ssed_pos #(
	parameter int MAX_WIDTH = 1024,
	parameter int COL_W = 10
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic advance,
	input wire logic frame_start,
	input wire ssed_pkg::cfg_t cfg,
	output logic [COL_W-1:0] addr,
	output ssed_pkg::pos_t pos
);

	localparam int WCW = ($clog2(MAX_WIDTH + 1) > ssed_pkg::FW_BITS) ?
		$clog2(MAX_WIDTH + 1) : ssed_pkg::FW_BITS;
	localparam int SUMW = WCW + 1;
	localparam int HSW = ssed_pkg::FH_BITS + 1;
	localparam int CCW = (COL_W > ssed_pkg::CCOL_BITS) ? COL_W : ssed_pkg::CCOL_BITS;

	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] col_cur;
	logic [ssed_pkg::ROW_BITS-1:0] row_q;
	logic [ssed_pkg::ROW_BITS-1:0] row_cur;
	logic [ssed_pkg::ROW_BITS-1:0] cr;
	logic [WCW-1:0] w_eff;
	logic [WCW-1:0] col_inc;
	logic [ssed_pkg::FH_BITS-1:0] h_eff;
	logic [ssed_pkg::FH_BITS-1:0] row_inc;
	logic [ssed_pkg::SB_BITS-1:0] sb_eff;
	logic [CCW-1:0] cc_full;
	logic [SUMW-1:0] cc_s;
	logic valid;

	always_comb begin
		if (WCW'(cfg.frame_width) > WCW'(MAX_WIDTH)) begin
			w_eff = WCW'(MAX_WIDTH);
		end else if (cfg.frame_width == '0) begin
			w_eff = WCW'(1);
		end else begin
			w_eff = WCW'(cfg.frame_width);
		end
		if (cfg.frame_height > ssed_pkg::FH_BITS'(ssed_pkg::MAX_HEIGHT)) begin
			h_eff = ssed_pkg::FH_BITS'(ssed_pkg::MAX_HEIGHT);
		end else if (cfg.frame_height == '0) begin
			h_eff = ssed_pkg::FH_BITS'(1);
		end else begin
			h_eff = cfg.frame_height;
		end
		sb_eff = (cfg.scan_border == '0) ? ssed_pkg::SB_BITS'(1) : cfg.scan_border;

		col_cur = frame_start ? '0 : col_q;
		row_cur = frame_start ? '0 : row_q;
		if (WCW'(col_cur) >= w_eff) begin
			col_cur = '0;
		end
		if (ssed_pkg::FH_BITS'(row_cur) >= h_eff) begin
			row_cur = '0;
		end

		cr = row_cur - ssed_pkg::ROW_BITS'(1);
		cc_full = CCW'(col_cur) - CCW'(1);
		cc_s = SUMW'(col_cur) - SUMW'(1);
		valid = (row_cur != '0) && (col_cur != '0)
			&& (cr >= ssed_pkg::ROW_BITS'(sb_eff))
			&& (HSW'(cr) + HSW'(sb_eff) + HSW'(1) <= HSW'(h_eff))
			&& (cc_s >= SUMW'(sb_eff))
			&& (cc_s + SUMW'(sb_eff) + SUMW'(1) <= SUMW'(w_eff));

		col_inc = WCW'(col_cur) + WCW'(1);
		row_inc = ssed_pkg::FH_BITS'(row_cur) + ssed_pkg::FH_BITS'(1);

		addr = col_cur;
		pos.center_valid = valid;
		pos.center_row = cr;
		pos.center_col = cc_full[ssed_pkg::CCOL_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_inc >= w_eff) begin
				col_q <= '0;
				if (row_inc >= h_eff) begin
					row_q <= '0;
				end else begin
					row_q <= row_inc[ssed_pkg::ROW_BITS-1:0];
				end
			end else begin
				col_q <= col_inc[COL_W-1:0];
				row_q <= row_cur;
			end
		end
	end

endmodule

`default_nettype wire

### src/ssed_win.sv
`default_nettype none

module ssed_win (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic shift,
	input wire ssed_pkg::sample_t new_col [ssed_pkg::PLANES][3],
	output logic no_greater,
	output logic no_smaller,
	output ssed_pkg::sample_t centre
);

	ssed_pkg::sample_t win_q [ssed_pkg::PLANES][3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < ssed_pkg::PLANES; p++) begin
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						win_q[p][i][j] <= '0;
					end
				end
			end
		end else if (shift) begin
			for (int p = 0; p < ssed_pkg::PLANES; p++) begin
				for (int i = 0; i < 3; i++) begin
					win_q[p][i][0] <= win_q[p][i][1];
					win_q[p][i][1] <= win_q[p][i][2];
					win_q[p][i][2] <= new_col[p][i];
				end
			end
		end
	end

	always_comb begin
		centre = win_q[1][1][1];
		no_greater = 1'b1;
		no_smaller = 1'b1;
		for (int p = 0; p < ssed_pkg::PLANES; p++) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (centre > win_q[p][i][j]) begin
						no_greater = 1'b0;
					end
					if (centre < win_q[p][i][j]) begin
						no_smaller = 1'b0;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

### src/scale_space_extremum_detect.sv
`default_nettype none

// Tests every middle-plane pixel of three streamed difference-of-Gaussian planes against its
// 3x3x3 neighborhood and reports one result per input sample triple, for the pixel one row up
// and one column left of that sample. The block sustains one transaction per clock unless
// results stall: the two previous rows of all three planes sit in a single line memory of
// MAX_WIDTH entries, read at the sample's column when the sample is taken and written back
// when it moves on from the first stage, with the pending write forwarded when the next sample
// hits the same column. A result is held in an output register while the next samples flow.
// Configuration is written while no transaction is in flight: a user rule the block does not enforce.
module scale_space_extremum_detect #(
	parameter int MAX_WIDTH = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic sample_valid,
	output logic sample_ready,
	input wire ssed_pkg::in_t sample,
	output logic result_valid,
	input wire logic result_ready,
	output ssed_pkg::out_t result,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [ssed_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input wire logic [ssed_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int SB = ssed_pkg::SAMPLE_BITS;
	localparam int LB = ssed_pkg::LINE_BITS;

	ssed_pkg::cfg_t cfg_q;
	ssed_pkg::pos_t pos;
	ssed_pkg::pos_t pos_s1;
	ssed_pkg::pos_t pos_s2;
	ssed_pkg::out_t result_q;
	ssed_pkg::sample_t smp_s1 [ssed_pkg::PLANES];
	ssed_pkg::sample_t new_col [ssed_pkg::PLANES][3];
	ssed_pkg::sample_t centre;

	logic [COL_W-1:0] addr;
	logic [COL_W-1:0] addr_s1;
	logic [ssed_pkg::ENTRY_BITS-1:0] ram_rdata;
	logic [ssed_pkg::ENTRY_BITS-1:0] ram_wdata;
	logic [ssed_pkg::ENTRY_BITS-1:0] line_entry;
	logic [ssed_pkg::ENTRY_BITS-1:0] fwd_data_s1;
	logic fwd_hit_s1;
	logic s1_valid_q;
	logic s2_valid_q;
	logic result_valid_q;
	logic accept;
	logic s1_move;
	logic s2_move;
	logic no_greater;
	logic no_smaller;
	logic is_min;
	logic is_max;
	logic det;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width <= ssed_pkg::FW_RESET;
			cfg_q.frame_height <= ssed_pkg::FH_RESET;
			cfg_q.scan_border <= ssed_pkg::SB_RESET;
			cfg_q.detect_mode <= ssed_pkg::MODE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				ssed_pkg::REG_FRAME_WIDTH: begin
					cfg_q.frame_width <= cfg_data[ssed_pkg::FW_BITS-1:0];
				end
				ssed_pkg::REG_FRAME_HEIGHT: begin
					cfg_q.frame_height <= cfg_data[ssed_pkg::FH_BITS-1:0];
				end
				ssed_pkg::REG_SCAN_BORDER: begin
					cfg_q.scan_border <= cfg_data[ssed_pkg::SB_BITS-1:0];
				end
				ssed_pkg::REG_DETECT_MODE: begin
					cfg_q.detect_mode <= cfg_data[ssed_pkg::MODE_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign s2_move = s2_valid_q && (!result_valid_q || result_ready);
	assign s1_move = s1_valid_q && (!s2_valid_q || s2_move);
	assign sample_ready = !s1_valid_q || s1_move;
	assign accept = sample_valid && sample_ready;

	ssed_pos #(
		.MAX_WIDTH(MAX_WIDTH),
		.COL_W(COL_W)
	) u_pos (
		.clk(clk),
		.arst_n(arst_n),
		.advance(accept),
		.frame_start(sample.frame_start),
		.cfg(cfg_q),
		.addr(addr),
		.pos(pos)
	);

	ssed_ram #(
		.WIDTH(ssed_pkg::ENTRY_BITS),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk(clk),
		.we(s1_move),
		.waddr(addr_s1),
		.wdata(ram_wdata),
		.re(accept),
		.raddr(addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		line_entry = fwd_hit_s1 ? fwd_data_s1 : ram_rdata;
		for (int p = 0; p < ssed_pkg::PLANES; p++) begin
			ram_wdata[p*LB +: LB] = {line_entry[p*LB +: SB], smp_s1[p]};
			new_col[p][0] = line_entry[p*LB+SB +: SB];
			new_col[p][1] = line_entry[p*LB +: SB];
			new_col[p][2] = smp_s1[p];
		end
	end

	ssed_win u_win (
		.clk(clk),
		.arst_n(arst_n),
		.shift(s1_move),
		.new_col(new_col),
		.no_greater(no_greater),
		.no_smaller(no_smaller),
		.centre(centre)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				s2_valid_q <= 1'b1;
			end else if (s2_move) begin
				s2_valid_q <= 1'b0;
			end
			if (s2_move) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// A write-back landing on the same edge as a read of the same column is not yet visible
	// in the memory's read data, so it is captured here and substituted.
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1 <= pos;
			addr_s1 <= addr;
			smp_s1[0] <= sample.sample_below;
			smp_s1[1] <= sample.sample_mid;
			smp_s1[2] <= sample.sample_above;
			fwd_hit_s1 <= s1_move && (addr_s1 == addr);
			fwd_data_s1 <= ram_wdata;
		end
		if (s1_move) begin
			pos_s2 <= pos_s1;
		end
		if (s2_move) begin
			result_q <= {pos_s2.center_valid, is_min, is_max, det && pos_s2.center_valid,
				pos_s2.center_row, pos_s2.center_col,
				pos_s2.center_valid ? centre : ssed_pkg::sample_t'(0)};
		end
	end

	always_comb begin
		is_min = no_greater && pos_s2.center_valid;
		is_max = no_smaller && pos_s2.center_valid;
		case (cfg_q.detect_mode)
			ssed_pkg::MODE_MIN: det = is_min;
			ssed_pkg::MODE_MAX: det = is_max;
			default: det = is_min || is_max;
		endcase
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

`default_nettype wire
